// ----- rtl/fcpm_pkg.sv -----
// ----------------------------------------------------------------------------
// fcpm_pkg
// Shared types and constants of the false-color pixel mapper.
// ----------------------------------------------------------------------------
package fcpm_pkg;

	typedef enum logic [2:0] {
		MODE_GREY     = 3'd0,
		MODE_PALETTE  = 3'd1,
		MODE_RGB      = 3'd2,
		MODE_INVERT   = 3'd3,
		MODE_DIVERGE  = 3'd4
	} mode_t;

	localparam logic [1:0] CLASS_NORMAL  = 2'd0;
	localparam logic [1:0] CLASS_OUTSIDE = 2'd1;
	localparam logic [1:0] CLASS_NAN     = 2'd2;
	localparam logic [1:0] CLASS_INF     = 2'd3;

	localparam logic [1:0] REG_COLOR_MODE    = 2'd0;
	localparam logic [1:0] REG_MIN_VALUE     = 2'd1;
	localparam logic [1:0] REG_NORM_SCALE    = 2'd2;
	localparam logic [1:0] REG_DIVERGE_SCALE = 2'd3;

	localparam int SCALE_BITS = 26;
	localparam int CHAN_BITS  = 8;

	localparam logic [23:0] COLOR_OUTSIDE = 24'h305050;
	localparam logic [23:0] COLOR_NAN     = 24'h406060;
	localparam logic [23:0] COLOR_INF     = 24'h905050;

	localparam logic [2:0] PAL_STEPS = 3'd6;

	// palette entries as {red, green, blue} on/off
	localparam logic [2:0] PALETTE [7] = '{
		3'b000, 3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b111
	};

	typedef struct packed {
		logic       is_wr;
		logic       pos;
		logic [1:0] cls;
	} ctl_t;

endpackage

// ----- rtl/false_color_pixel_mapper.sv -----
// ----------------------------------------------------------------------------
// false_color_pixel_mapper
// Maps signed samples to RGB pixels through a scale, a gamma table and a
// color mode; three parallel lanes feed one merge stage.
// ----------------------------------------------------------------------------
// Stages: lane offset, product, gamma address and gamma read, merge, output.
// Throughput: one item per cycle unless the output stalls; the three lanes
// each own a gamma RAM copy. Reset: arst_n clears control and registers to
// their defaults, then a clearing pass loads the identity gamma table; no item
// is accepted during that pass, configuration writes are.
module false_color_pixel_mapper
	import fcpm_pkg::*;
#(
	parameter int AMP_BITS    = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic signed [SAMPLE_BITS-1:0] sample_now,
	input  logic signed [SAMPLE_BITS-1:0] sample_next,
	input  logic signed [SAMPLE_BITS-1:0] sample_after,
	input  logic [1:0]                    sample_class,
	input  logic [AMP_BITS-1:0]           table_index,
	input  logic [AMP_BITS-1:0]           table_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue
);

	localparam logic [AMP_BITS-1:0] AMAX = {AMP_BITS{1'b1}};
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(65472);

	// configuration registers
	logic [2:0]                    color_mode_q;
	logic signed [SAMPLE_BITS-1:0] min_value_q;
	logic [SCALE_BITS-1:0]         norm_scale_q;
	logic [SCALE_BITS-1:0]         diverge_scale_q;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q    <= MODE_GREY;
			min_value_q     <= '0;
			norm_scale_q    <= SCALE_RESET;
			diverge_scale_q <= SCALE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_COLOR_MODE:    color_mode_q    <= pwdata[2:0];
				REG_MIN_VALUE:     min_value_q     <= pwdata[SAMPLE_BITS-1:0];
				REG_NORM_SCALE:    norm_scale_q    <= pwdata[SCALE_BITS-1:0];
				REG_DIVERGE_SCALE: diverge_scale_q <= pwdata[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_COLOR_MODE:    prdata = 32'(color_mode_q);
			REG_MIN_VALUE:     prdata = 32'(min_value_q);
			REG_NORM_SCALE:    prdata = 32'(norm_scale_q);
			REG_DIVERGE_SCALE: prdata = 32'(diverge_scale_q);
			default:           prdata = '0;
		endcase
	end

	// gamma clearing pass after reset: write entry i with i
	logic                clr_busy_q;
	logic [AMP_BITS-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AMP_BITS'(1);
			if (clr_cnt_q == AMAX) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// pipeline control: whole pipe advances when the output slot frees up
	logic adv;
	logic accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;
	ctl_t ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [AMP_BITS-1:0] wa_s1, wa_s2, wa_s3;
	logic [AMP_BITS-1:0] wd_s1, wd_s2, wd_s3;
	logic                tbl_wr;
	logic                ram_we;
	logic [AMP_BITS-1:0] ram_wa, ram_wd;

	assign adv      = !out_v_q || out_ready;
	assign in_ready = adv && !clr_busy_q;
	assign accept   = in_valid && in_ready;

	assign ctl_in.is_wr = action;
	assign ctl_in.pos   = !sample_now[SAMPLE_BITS-1] && (sample_now != '0);
	assign ctl_in.cls   = sample_class;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			wa_s1  <= table_index;
			wd_s1  <= table_value;
			wa_s2  <= wa_s1;
			wd_s2  <= wd_s1;
			wa_s3  <= wa_s2;
			wd_s3  <= wd_s2;
		end
	end

	// table write lands at the read stage so later items see it in order
	assign tbl_wr = adv && v_s3 && ctl_s3.is_wr;
	assign ram_we = clr_busy_q || tbl_wr;
	assign ram_wa = clr_busy_q ? clr_cnt_q : wa_s3;
	assign ram_wd = clr_busy_q ? clr_cnt_q : wd_s3;

	logic                  dvg;
	logic [SCALE_BITS-1:0] lane_scale;
	logic [AMP_BITS-1:0]   g0, g1, g2;

	assign dvg        = (color_mode_q == MODE_DIVERGE);
	assign lane_scale = dvg ? diverge_scale_q : norm_scale_q;

	fcpm_lane #(.AMP_BITS(AMP_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_lane0 (
		.clk(clk), .en(adv), .sample(sample_now), .min_value(min_value_q),
		.scale(lane_scale), .dvg(dvg), .wr_en(ram_we), .wr_addr(ram_wa),
		.wr_data(ram_wd), .gamma(g0)
	);

	fcpm_lane #(.AMP_BITS(AMP_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_lane1 (
		.clk(clk), .en(adv), .sample(sample_next), .min_value(min_value_q),
		.scale(lane_scale), .dvg(dvg), .wr_en(ram_we), .wr_addr(ram_wa),
		.wr_data(ram_wd), .gamma(g1)
	);

	fcpm_lane #(.AMP_BITS(AMP_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_lane2 (
		.clk(clk), .en(adv), .sample(sample_after), .min_value(min_value_q),
		.scale(lane_scale), .dvg(dvg), .wr_en(ram_we), .wr_addr(ram_wa),
		.wr_data(ram_wd), .gamma(g2)
	);

	logic        keep;
	logic [23:0] rgb;

	fcpm_merge #(.AMP_BITS(AMP_BITS)) u_merge (
		.clk(clk), .en(adv), .mode(color_mode_q), .ctl_s4(ctl_s4),
		.g0(g0), .g1(g1), .g2(g2), .keep(keep), .rgb(rgb)
	);

	// output register; table writes drop here without a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s5 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			{red, green, blue} <= rgb;
		end
	end

	assign out_valid = out_v_q;

`ifndef ASSERT_OFF
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || out_v_q))
		else $error("pipeline holds items during gamma clearing");

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(clr_busy_q && tbl_wr))
		else $error("table write collides with clearing pass");

	a_out_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s5 && keep))
		else $error("result without a map item at the last stage");
`endif

endmodule

// ----- rtl/fcpm_ram.sv -----
// ----------------------------------------------------------------------------
// fcpm_ram
// Generic single-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module fcpm_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/fcpm_lane.sv -----
// ----------------------------------------------------------------------------
// fcpm_lane
// One sample lane: offset or abs, scale, saturate, gamma lookup (four stages).
// ----------------------------------------------------------------------------
module fcpm_lane
	import fcpm_pkg::*;
#(
	parameter int AMP_BITS    = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] min_value,
	input  logic [SCALE_BITS-1:0]         scale,
	input  logic                          dvg,
	input  logic                          wr_en,
	input  logic [AMP_BITS-1:0]           wr_addr,
	input  logic [AMP_BITS-1:0]           wr_data,
	output logic [AMP_BITS-1:0]           gamma
);

	localparam int PW = SAMPLE_BITS + SCALE_BITS;
	localparam logic [AMP_BITS-1:0] AMAX = {AMP_BITS{1'b1}};

	logic signed [SAMPLE_BITS:0] diff;
	logic signed [SAMPLE_BITS:0] neg;
	logic [SAMPLE_BITS-1:0]      op;
	logic [SAMPLE_BITS-1:0]      op_s1;
	logic [SCALE_BITS-1:0]       scale_s1;
	logic [PW-1:0]               prod_s2;
	logic [PW-17:0]              hi;
	logic [AMP_BITS-1:0]         amp;
	logic [AMP_BITS-1:0]         addr_s3;

	always_comb begin
		diff = {sample[SAMPLE_BITS-1], sample} - {min_value[SAMPLE_BITS-1], min_value};
		neg  = -{sample[SAMPLE_BITS-1], sample};
		if (dvg) begin
			if (!sample[SAMPLE_BITS-1] && sample != '0) begin
				op = sample[SAMPLE_BITS-1:0];
			end else begin
				op = neg[SAMPLE_BITS-1:0];
			end
		end else if (diff[SAMPLE_BITS] || diff == '0) begin
			op = '0;
		end else begin
			op = diff[SAMPLE_BITS-1:0];
		end
	end

	// saturate the Q16 product to full amplitude
	always_comb begin
		hi = prod_s2[PW-1:16];
		if (|hi[PW-17:AMP_BITS]) begin
			amp = AMAX;
		end else begin
			amp = hi[AMP_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= op;
			scale_s1 <= scale;
			prod_s2  <= PW'(op_s1) * PW'(scale_s1);
			addr_s3  <= amp;
		end
	end

	fcpm_ram #(
		.WIDTH (AMP_BITS),
		.DEPTH (1 << AMP_BITS)
	) u_gamma (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (en),
		.raddr (addr_s3),
		.rdata (gamma)
	);

endmodule

// ----- rtl/fcpm_merge.sv -----
// ----------------------------------------------------------------------------
// fcpm_merge
// Combines the three lane amplitudes into one pixel per color mode.
// ----------------------------------------------------------------------------
module fcpm_merge
	import fcpm_pkg::*;
#(
	parameter int AMP_BITS = 10
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [2:0]           mode,
	input  ctl_t                 ctl_s4,
	input  logic [AMP_BITS-1:0]  g0,
	input  logic [AMP_BITS-1:0]  g1,
	input  logic [AMP_BITS-1:0]  g2,
	output logic                 keep,
	output logic [23:0]          rgb
);

	localparam int XW = AMP_BITS + 8;
	localparam logic [AMP_BITS-1:0] AMAX = {AMP_BITS{1'b1}};

	// floor(x / AMAX) and remainder by folding modulo 2^AMP_BITS - 1
	function automatic logic [XW+7:0] div_amax(input logic [XW-1:0] x);
		logic [XW-1:0] q1, r1, q2, r2, q;
		q1 = x >> AMP_BITS;
		r1 = (x & XW'(AMAX)) + q1;
		q2 = r1 >> AMP_BITS;
		r2 = (r1 & XW'(AMAX)) + q2;
		q  = q1 + q2;
		if (r2 >= XW'(AMAX)) begin
			q  = q + XW'(1);
			r2 = r2 - XW'(AMAX);
		end
		return {q[7:0], r2};
	endfunction

	function automatic logic [7:0] chan(input logic [AMP_BITS-1:0] v);
		logic [XW-1:0]   x;
		logic [XW+7:0]   d;
		x = (XW'(v) << 8) - XW'(v);
		d = div_amax(x);
		return d[XW+7:XW];
	endfunction

	logic [AMP_BITS-1:0] v    [3];
	logic [AMP_BITS-1:0] v_s5 [3];
	logic [XW+7:0]       pd;
	logic [2:0]          idx_s5;
	logic [AMP_BITS-1:0] fr_s5;
	logic                pal_s5;
	ctl_t                ctl_s5;
	logic [2:0]          pe0, pe1;
	logic [AMP_BITS-1:0] pv   [3];
	logic [7:0]          ch   [3];

	always_comb begin
		pd = div_amax(XW'(g0) * XW'(PAL_STEPS));
		v[0] = g0;
		v[1] = g0;
		v[2] = g0;
		case (mode)
			MODE_RGB: begin
				v[1] = g1;
				v[2] = g2;
			end
			MODE_INVERT: begin
				v[0] = AMAX - g0;
				v[1] = AMAX - g0;
				v[2] = AMAX - g0;
			end
			MODE_DIVERGE: begin
				v[1] = '0;
				v[0] = ctl_s4.pos ? g0 : '0;
				v[2] = ctl_s4.pos ? '0 : g0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s5   <= v;
			idx_s5 <= pd[XW+2:XW];
			fr_s5  <= pd[AMP_BITS-1:0];
			pal_s5 <= (mode == MODE_PALETTE);
			ctl_s5 <= ctl_s4;
		end
	end

	// interpolate between two on/off palette entries
	always_comb begin
		pe0 = '0;
		pe1 = '0;
		if (idx_s5 < PAL_STEPS) begin
			pe0 = PALETTE[idx_s5];
			pe1 = PALETTE[idx_s5 + 3'd1];
		end
		for (int k = 0; k < 3; k++) begin
			if (pe0[2-k] && pe1[2-k]) begin
				pv[k] = AMAX;
			end else if (pe0[2-k]) begin
				pv[k] = AMAX - fr_s5;
			end else if (pe1[2-k]) begin
				pv[k] = fr_s5;
			end else begin
				pv[k] = '0;
			end
			if (pal_s5 && idx_s5 >= PAL_STEPS) begin
				ch[k] = 8'hFF;
			end else begin
				ch[k] = chan(pal_s5 ? pv[k] : v_s5[k]);
			end
		end
	end

	always_comb begin
		keep = !ctl_s5.is_wr;
		case (ctl_s5.cls)
			CLASS_OUTSIDE: rgb = COLOR_OUTSIDE;
			CLASS_NAN:     rgb = COLOR_NAN;
			CLASS_INF:     rgb = COLOR_INF;
			default:       rgb = {ch[0], ch[1], ch[2]};
		endcase
	end

endmodule

// ----- sim/fcpm_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcpm_checker
// Watches the pixel mapper's item channels and register port, keeps its own
// gamma table and register copies, predicts each pixel and compares it.
// ----------------------------------------------------------------------------
module fcpm_checker
	import fcpm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic signed [15:0] sample_now,
	input  logic signed [15:0] sample_next,
	input  logic signed [15:0] sample_after,
	input  logic [1:0]         sample_class,
	input  logic [9:0]         table_index,
	input  logic [9:0]         table_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output int                 fail_count,
	output int                 pixels_pending
);

	localparam int AMAX = 1023;

	logic [2:0]         mode_q;
	logic signed [15:0] min_q;
	logic [25:0]        nscale_q;
	logic [25:0]        dscale_q;
	logic [9:0]         gamma_q [1024];
	logic [23:0]        pixel_q [$];

	// clamp, scale, saturate and look up through gamma
	function automatic int gamma_amp(longint diff, logic [25:0] scale);
		longint a;
		a = (diff <= 0) ? 0 : ((diff * longint'(scale)) >>> 16);
		if (a > AMAX)
			a = AMAX;
		return int'(gamma_q[a]);
	endfunction

	function automatic logic [7:0] to_chan(int g);
		return 8'((255 * g) / AMAX);
	endfunction

	function automatic logic [23:0] predict_pixel(logic signed [15:0] s0,
		logic signed [15:0] s1, logic signed [15:0] s2, logic [1:0] cls);
		int g, t, idx, fr;
		logic [7:0] c [3];
		if (cls == CLASS_OUTSIDE)
			return COLOR_OUTSIDE;
		if (cls == CLASS_NAN)
			return COLOR_NAN;
		if (cls == CLASS_INF)
			return COLOR_INF;
		case (mode_q)
			MODE_PALETTE: begin
				g = gamma_amp(longint'(s0) - longint'(min_q), nscale_q);
				t = g * 6;
				idx = t / AMAX;
				fr = t % AMAX;
				for (int k = 0; k < 3; k++) begin
					if (idx >= 6)
						c[k] = 8'd255;
					else
						c[k] = 8'((255 * (int'(PALETTE[idx][2-k]) * (AMAX - fr)
							+ int'(PALETTE[idx+1][2-k]) * fr)) / AMAX);
				end
				return {c[0], c[1], c[2]};
			end
			MODE_RGB:
				return {to_chan(gamma_amp(longint'(s0) - longint'(min_q), nscale_q)),
					to_chan(gamma_amp(longint'(s1) - longint'(min_q), nscale_q)),
					to_chan(gamma_amp(longint'(s2) - longint'(min_q), nscale_q))};
			MODE_INVERT: begin
				g = gamma_amp(longint'(s0) - longint'(min_q), nscale_q);
				c[0] = 8'((255 * (AMAX - g)) / AMAX);
				return {c[0], c[0], c[0]};
			end
			MODE_DIVERGE: begin
				if (s0 > 0)
					return {to_chan(gamma_amp(longint'(s0), dscale_q)), 16'h0};
				return {16'h0, to_chan(gamma_amp(-longint'(s0), dscale_q))};
			end
			default: begin
				c[0] = to_chan(gamma_amp(longint'(s0) - longint'(min_q), nscale_q));
				return {c[0], c[0], c[0]};
			end
		endcase
	endfunction

	assign pixels_pending = pixel_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [23:0] want;
		if (!arst_n) begin
			mode_q = MODE_GREY;
			min_q = '0;
			nscale_q = 26'd65472;
			dscale_q = 26'd65472;
			for (int i = 0; i < 1024; i++)
				gamma_q[i] = 10'(i);
			pixel_q.delete();
			fail_count = 0;
		end else begin
			// check before predicting: an item in the same cycle cannot exit yet
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected pixel %02h %02h %02h", red, green, blue);
				end else begin
					want = pixel_q.pop_front();
					if ({red, green, blue} !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("pixel mismatch: expected %06h got %02h%02h%02h",
								want, red, green, blue);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (action)
					gamma_q[table_index] = table_value;
				else
					pixel_q.push_back(predict_pixel(sample_now, sample_next,
						sample_after, sample_class));
			end
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_COLOR_MODE:    mode_q = pwdata[2:0];
					REG_MIN_VALUE:     min_q = pwdata[15:0];
					REG_NORM_SCALE:    nscale_q = pwdata[25:0];
					REG_DIVERGE_SCALE: dscale_q = pwdata[25:0];
				endcase
			end
		end
	end

endmodule

// ----- sim/tb_false_color_pixel_mapper.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_false_color_pixel_mapper
// Drives register settings and pixel/gamma items into the mapper with bursty
// input and a stalling sink; the checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_false_color_pixel_mapper;
	import fcpm_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic action = 1'b0;
	logic signed [15:0] sample_now = '0, sample_next = '0, sample_after = '0;
	logic [1:0] sample_class = '0;
	logic [9:0] table_index = '0, table_value = '0;
	logic out_valid, out_ready = 1'b0;
	logic [7:0] red, green, blue;
	int fail_count, pixels_pending;
	int idle_cycles = 0;
	int stall_mode = 0;

	always #5 clk = ~clk;

	false_color_pixel_mapper dut (.*);
	fcpm_checker chk (.*);

	// Sink stall pattern: phases of always-ready, heavy stall and light stall.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Watchdog: count cycles where nothing moves; covers the clearing pass.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Present one item and hold it until accepted; valid stays up between items.
	task automatic send_item(logic act, logic signed [15:0] s0, logic signed [15:0] s1,
		logic signed [15:0] s2, logic [1:0] cls, logic [9:0] ti, logic [9:0] tv);
		in_valid <= 1'b1;
		action <= act;
		sample_now <= s0;
		sample_next <= s1;
		sample_after <= s2;
		sample_class <= cls;
		table_index <= ti;
		table_value <= tv;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_pixel(logic signed [15:0] s0, logic [1:0] cls);
		send_item(1'b0, s0, 16'(~s0), 16'(s0 >>> 1), cls, 10'($urandom), 10'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pixels_pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_items(int count);
		int burst;
		logic r;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && count > 0; i++, count--) begin
				r = ($urandom_range(0, 9) == 0);
				// mostly normal samples, an eighth of each special class mixed in
				send_item(r, 16'($urandom), 16'($urandom), 16'($urandom),
					($urandom_range(0, 5) < 3) ? CLASS_NORMAL : 2'($urandom),
					10'($urandom), 10'($urandom));
			end
			// gap: drop valid for a random stretch, sometimes none
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every mode, sample extremes, special classes, table write
		for (int m = 0; m < 8; m++) begin
			reg_write(REG_COLOR_MODE, 32'(m));
			send_pixel(16'sh7fff, CLASS_NORMAL);
			send_pixel(-16'sh8000, CLASS_NORMAL);
			send_pixel(16'sh0000, CLASS_NORMAL);
			send_pixel(16'sh03ff, CLASS_NORMAL);
			drain();
		end
		send_pixel(16'sh0, CLASS_OUTSIDE);
		send_pixel(16'sh0, CLASS_NAN);
		send_pixel(16'sh0, CLASS_INF);
		send_item(1'b1, 16'sh0, 16'sh0, 16'sh0, CLASS_NORMAL, 10'h3ff, 10'h000);
		send_item(1'b1, 16'sh0, 16'sh0, 16'sh0, CLASS_NORMAL, 10'h000, 10'h3ff);
		send_pixel(16'sh7fff, CLASS_NORMAL);
		send_pixel(16'sh0000, CLASS_NORMAL);
		drain();

		// random phases over several register settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			reg_write(REG_COLOR_MODE, (ph < 5) ? 32'(ph) : 32'($urandom_range(0, 7)));
			case (ph % 4)
				0: reg_write(REG_MIN_VALUE, 32'hffff8000);
				1: reg_write(REG_MIN_VALUE, 32'h00007fff);
				default: reg_write(REG_MIN_VALUE, 32'($signed(16'($urandom))));
			endcase
			case (ph % 3)
				0: reg_write(REG_NORM_SCALE, 32'd1023);
				1: reg_write(REG_NORM_SCALE, 32'd67043328);
				default: reg_write(REG_NORM_SCALE, 32'($urandom_range(0, 200000)));
			endcase
			case (ph % 3)
				0: reg_write(REG_DIVERGE_SCALE, 32'd0);
				1: reg_write(REG_DIVERGE_SCALE, 32'd67043328);
				default: reg_write(REG_DIVERGE_SCALE, 32'($urandom_range(1000, 200000)));
			endcase
			random_items(160);
			drain();
		end

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fcpm_pkg.sv
rtl/fcpm_ram.sv
rtl/fcpm_lane.sv
rtl/fcpm_merge.sv
rtl/false_color_pixel_mapper.sv
sim/fcpm_checker.sv
sim/tb_false_color_pixel_mapper.sv
